### rtl/tmr_pkg.sv
// Shared types and constants for the tile map row renderer.
package tmr_pkg;

   typedef enum logic [1:0] {
      KIND_TILESET = 2'd0,
      KIND_MAP     = 2'd1,
      KIND_RENDER  = 2'd2
   } kind_type;

   localparam int TILE_SIZE    = 8;
   localparam int TILE_ROW_W   = 3;
   localparam int TILE_INDEX_W = 14;
   localparam int ORIENT_V_BIT = 14;
   localparam int ORIENT_H_BIT = 15;

   localparam logic CSR_PITCH = 1'b0;
   localparam logic CSR_WIDTH = 1'b1;

   localparam logic [15:0] PITCH_RESET = 16'd512;
   localparam logic [8:0]  WIDTH_RESET = 9'd32;

endpackage

### rtl/tmr_byte_bank.sv
// One byte-wide tileset bank: one write port, one registered read port.
module tmr_byte_bank #(
   parameter int WORDS = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(WORDS)-1:0] waddr,
   input  logic [7:0]               wdata,
   input  logic [$clog2(WORDS)-1:0] raddr,
   output logic [7:0]               rdata
);

   logic [7:0] mem [WORDS];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/tile_map_row_renderer.sv
// Top level of the tile map row renderer: pipeline, tile map store and CSRs.
//
// One beat enters per cycle (start with busy low); busy is never raised and the
// receiver cannot stall. A render beat returns its eight packed pixels on
// rsp_pixels with rsp_valid after the input, map index, tile map, tileset base,
// tileset bank and output registers; write beats and kind 3 give no result.
// Writes land in the stores in order with renders, so a render sees every write
// accepted before it. Depth comes from the two dependent store reads (tile map,
// then tileset) and their address math; the tileset's eight byte banks let a
// segment at any byte alignment be read in one access. TILESET_BYTES and
// TILE_MAP_ENTRIES must be powers of two. No clearing pass: stores power up undefined.
module tile_map_row_renderer #(
   parameter int TILESET_BYTES    = 65536,
   parameter int TILE_MAP_ENTRIES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_address,
   input  logic [15:0] req_data,
   input  logic [14:0] req_pixel_row,
   input  logic [7:0]  req_tile_column,
   output logic        rsp_valid,
   output logic [63:0] rsp_pixels,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tmr_pkg::*;

   localparam int TS_AW   = $clog2(TILESET_BYTES);
   localparam int BANK_AW = TS_AW - TILE_ROW_W;
   localparam int MAP_AW  = $clog2(TILE_MAP_ENTRIES);

   // ---------------- CSRs ----------------
   logic [15:0] pitch_ff, pitch_in;
   logic [8:0]  width_ff, width_in;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      pitch_in = pitch_ff;
      width_in = width_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == CSR_PITCH) begin
            pitch_in = csr_pwdata[15:0];
         end else begin
            width_in = csr_pwdata[8:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff <= PITCH_RESET;
         width_ff <= WIDTH_RESET;
      end else begin
         pitch_ff <= pitch_in;
         width_ff <= width_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_WIDTH) ? {23'd0, width_ff} : {16'd0, pitch_ff};

   assign busy = 1'b0;

   // ---------------- stage A: input register ----------------
   logic        a_valid_ff;
   kind_type    a_kind_ff;
   logic [15:0] a_address_ff;
   logic [15:0] a_data_ff;
   logic [14:0] a_prow_ff;
   logic [7:0]  a_tcol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
      end
      a_kind_ff    <= kind_type'(req_kind);
      a_address_ff <= req_address;
      a_data_ff    <= req_data;
      a_prow_ff    <= req_pixel_row;
      a_tcol_ff    <= req_tile_column;
   end

   // ---------------- stage B: map index ----------------
   logic [20:0]       a_prod;
   logic [21:0]       a_idx_sum;
   logic              b_valid_ff;
   kind_type          b_kind_ff;
   logic [15:0]       b_address_ff;
   logic [15:0]       b_data_ff;
   logic [2:0]        b_r_ff;
   logic [MAP_AW-1:0] b_idx_ff;

   assign a_prod    = 21'(a_prow_ff[14:3]) * 21'(width_ff);
   assign a_idx_sum = 22'(a_prod) + 22'(a_tcol_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_kind_ff    <= a_kind_ff;
      b_address_ff <= a_address_ff;
      b_data_ff    <= a_data_ff;
      b_r_ff       <= a_prow_ff[2:0];
      b_idx_ff     <= a_idx_sum[MAP_AW-1:0];
   end

   // ---------------- stage C: tile map store ----------------
   logic [15:0] map_mem [TILE_MAP_ENTRIES];
   logic        c_valid_ff;
   kind_type    c_kind_ff;
   logic [15:0] c_address_ff;
   logic [15:0] c_data_ff;
   logic [2:0]  c_r_ff;
   logic [15:0] c_entry_ff;

   always_ff @(posedge clock) begin
      if (b_valid_ff && b_kind_ff == KIND_MAP) begin
         map_mem[b_address_ff[MAP_AW-1:0]] <= b_data_ff;
      end
      c_entry_ff <= map_mem[b_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
      c_kind_ff    <= b_kind_ff;
      c_address_ff <= b_address_ff;
      c_data_ff    <= b_data_ff;
      c_r_ff       <= b_r_ff;
   end

   // ---------------- stage D: tileset base address ----------------
   logic [2:0]       c_row;
   logic [16:0]      c_tile_off;
   logic [18:0]      c_row_off;
   logic [19:0]      c_base_sum;
   logic             d_valid_ff;
   kind_type         d_kind_ff;
   logic [15:0]      d_address_ff;
   logic [7:0]       d_data_ff;
   logic             d_mirror_ff;
   logic [TS_AW-1:0] d_base_ff;

   assign c_row      = c_entry_ff[ORIENT_V_BIT] ? ~c_r_ff : c_r_ff;
   assign c_tile_off = {c_entry_ff[TILE_INDEX_W-1:0], 3'b000};
   assign c_row_off  = 19'(pitch_ff) * 19'(c_row);
   assign c_base_sum = 20'(c_tile_off) + 20'(c_row_off);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= c_valid_ff;
      end
      d_kind_ff    <= c_kind_ff;
      d_address_ff <= c_address_ff;
      d_data_ff    <= c_data_ff[7:0];
      d_mirror_ff  <= c_entry_ff[ORIENT_H_BIT];
      d_base_ff    <= c_base_sum[TS_AW-1:0];
   end

   // ---------------- stage E: tileset banks ----------------
   logic [19:0]        d_waddr_ext;
   logic [TS_AW-1:0]   d_waddr;
   logic [BANK_AW-1:0] d_word;
   logic [2:0]         d_lo;
   logic               d_ts_write;
   logic [7:0]         e_q [TILE_SIZE];
   logic               e_render_ff;
   logic               e_mirror_ff;
   logic [2:0]         e_lo_ff;

   assign d_waddr_ext = 20'(d_address_ff);
   assign d_waddr     = d_waddr_ext[TS_AW-1:0];
   assign d_word      = d_base_ff[TS_AW-1:TILE_ROW_W];
   assign d_lo        = d_base_ff[TILE_ROW_W-1:0];
   assign d_ts_write  = d_valid_ff && d_kind_ff == KIND_TILESET;

   for (genvar b = 0; b < TILE_SIZE; b++) begin : g_bank
      logic [BANK_AW-1:0] raddr;

      // banks below the start offset take the next word
      assign raddr = d_word + BANK_AW'((3'(b) < d_lo) ? 1 : 0);

      tmr_byte_bank #(
         .WORDS(TILESET_BYTES / TILE_SIZE)
      ) u_bank (
         .clock (clock),
         .we    (d_ts_write && d_waddr[TILE_ROW_W-1:0] == 3'(b)),
         .waddr (d_waddr[TS_AW-1:TILE_ROW_W]),
         .wdata (d_data_ff),
         .raddr (raddr),
         .rdata (e_q[b])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_render_ff <= 1'b0;
      end else begin
         e_render_ff <= d_valid_ff && d_kind_ff == KIND_RENDER;
      end
      e_mirror_ff <= d_mirror_ff;
      e_lo_ff     <= d_lo;
   end

   // ---------------- stage F: align, mirror, output ----------------
   logic [63:0] e_pixels;
   logic        rsp_valid_ff;
   logic [63:0] rsp_pixels_ff;

   always_comb begin
      logic [2:0] c;
      logic [2:0] bank;
      e_pixels = '0;
      for (int j = 0; j < TILE_SIZE; j++) begin
         c    = e_mirror_ff ? 3'(TILE_SIZE - 1 - j) : 3'(j);
         bank = e_lo_ff + c;
         e_pixels[8*j +: 8] = e_q[bank];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= e_render_ff;
      end
      rsp_pixels_ff <= e_pixels;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_pixels = rsp_pixels_ff;

   // ---------------- assertions ----------------
   a_render_gives_beat: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_kind == KIND_RENDER |-> ##6 rsp_valid)
      else $error("render beat produced no result");

   a_beat_has_render: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && req_kind == KIND_RENDER, 6))
      else $error("result without a render beat");

   a_pitch_holds: assert property (@(posedge clock) disable iff (reset)
      !csr_wr |=> $stable(pitch_ff) && $stable(width_ff))
      else $error("CSR changed without a write");

endmodule

### test/tb.sv
// Self-checking testbench for tile_map_row_renderer: directed table, then random phases.
`timescale 1ns / 1ps

module tb;
   import tmr_pkg::*;

   localparam logic [1:0]  KIND_UNUSED   = 2'd3;
   localparam logic [2:0]  PITCH_ADDR    = {CSR_PITCH, 2'b00};
   localparam logic [2:0]  WIDTH_ADDR    = {CSR_WIDTH, 2'b00};
   localparam int          NUM_PHASES    = 7;
   localparam int          PHASE_BEATS   = 275;
   localparam int          DRAIN_CYCLES  = 16;
   localparam int          REPORT_LIMIT  = 10;
   localparam int unsigned CYCLE_LIMIT   = 200000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] address;
      logic [15:0] data;
      logic [14:0] prow;
      logic [7:0]  tcol;
      logic        fixed;
      logic [63:0] pixels;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_kind = KIND_TILESET;
   logic [15:0] req_address = '0;
   logic [15:0] req_data = '0;
   logic [14:0] req_pixel_row = '0;
   logic [7:0]  req_tile_column = '0;
   logic        rsp_valid;
   logic [63:0] rsp_pixels;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic [7:0]  tileset_img [65536];
   bit          tileset_set [65536];
   logic [15:0] tile_map_img [4096];
   bit          tile_map_set [4096];
   logic [15:0] pitch_now = PITCH_RESET;
   logic [8:0]  width_now = WIDTH_RESET;

   logic [63:0]  pixels_due [$];
   logic [63:0]  want;
   stim_row_type directed_rows [$];
   int unsigned  beats_sent = 0;
   int unsigned  failures = 0;
   int unsigned  calm_beats = 0;
   int unsigned  cycle_count = 0;

   logic [15:0] phase_pitch [NUM_PHASES] =
      '{16'd512, 16'd8, 16'd65528, 16'd24, 16'd13, 16'd0, 16'd65535};
   logic [8:0]  phase_width [NUM_PHASES] =
      '{9'd32, 9'd1, 9'd256, 9'd40, 9'd0, 9'd511, 9'd300};

   tile_map_row_renderer u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_address     (req_address),
      .req_data        (req_data),
      .req_pixel_row   (req_pixel_row),
      .req_tile_column (req_tile_column),
      .rsp_valid       (rsp_valid),
      .rsp_pixels      (rsp_pixels),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic flag_failure(input string what, input logic [63:0] exp_val,
                               input logic [63:0] got_val);
      failures++;
      if (failures <= REPORT_LIMIT)
         $display("MISMATCH %s: expected %h, got %h", what, exp_val, got_val);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pixels_due.size() == 0) begin
            flag_failure("unexpected rsp beat", 'x, rsp_pixels);
         end else begin
            want = pixels_due.pop_front();
            if (rsp_pixels !== want)
               flag_failure("rsp_pixels", want, rsp_pixels);
         end
      end
   end

   function automatic logic [11:0] map_slot(input logic [14:0] prow, input logic [7:0] tcol);
      logic [31:0] slot;
      slot = 32'(prow[14:3]) * 32'(width_now) + 32'(tcol);
      return slot[11:0];
   endfunction

   // Byte address of pixel j (from the left) of the requested segment.
   function automatic logic [15:0] tile_byte_addr(input logic [14:0] prow,
                                                  input logic [7:0] tcol, input int j);
      logic [15:0] entry;
      logic [2:0]  row;
      logic [2:0]  col;
      logic [31:0] base;
      entry = tile_map_img[map_slot(prow, tcol)];
      row   = entry[ORIENT_V_BIT] ? ~prow[2:0] : prow[2:0];
      col   = entry[ORIENT_H_BIT] ? ~3'(j) : 3'(j);
      base  = 32'(entry[TILE_INDEX_W-1:0]) * TILE_SIZE + 32'(row) * 32'(pitch_now)
              + 32'(col);
      return base[15:0];
   endfunction

   function automatic logic [63:0] segment_pixels(input logic [14:0] prow,
                                                  input logic [7:0] tcol);
      logic [63:0] word;
      for (int j = 0; j < TILE_SIZE; j++)
         word[8*j +: 8] = tileset_img[tile_byte_addr(prow, tcol, j)];
      return word;
   endfunction

   function automatic int unsigned pick_gap();
      if (calm_beats != 0) begin
         calm_beats--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         calm_beats = $urandom_range(10, 60);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   function automatic logic [15:0] random_entry();
      logic [13:0] tile;
      tile = ($urandom_range(0, 9) < 7) ? 14'($urandom_range(0, 31)) : 14'($urandom);
      return {2'($urandom), tile};
   endfunction

   // Drive one beat, wait for acceptance, then update the shadow stores.
   task automatic send_beat(input logic [1:0] kind, input logic [15:0] address,
                            input logic [15:0] data, input logic [14:0] prow,
                            input logic [7:0] tcol, input logic fixed,
                            input logic [63:0] fixed_pixels);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_kind        <= kind;
      req_address     <= address;
      req_data        <= data;
      req_pixel_row   <= prow;
      req_tile_column <= tcol;
      start           <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      case (kind)
         KIND_TILESET: begin
            tileset_img[address] = data[7:0];
            tileset_set[address] = 1'b1;
         end
         KIND_MAP: begin
            tile_map_img[address[11:0]] = data;
            tile_map_set[address[11:0]] = 1'b1;
         end
         KIND_RENDER: begin
            pixels_due.push_back(fixed ? fixed_pixels : segment_pixels(prow, tcol));
         end
         default: ;
      endcase
      beats_sent++;
   endtask

   // Render beat preceded by writes to any map entry or tile byte it would read unwritten.
   task automatic render_checked(input logic [14:0] prow, input logic [7:0] tcol,
                                 input logic fixed, input logic [63:0] fixed_pixels);
      logic [11:0] slot;
      logic [15:0] addr;
      slot = map_slot(prow, tcol);
      if (!tile_map_set[slot])
         send_beat(KIND_MAP, {4'($urandom), slot}, random_entry(), 15'($urandom),
                   8'($urandom), 1'b0, '0);
      for (int j = 0; j < TILE_SIZE; j++) begin
         addr = tile_byte_addr(prow, tcol, j);
         if (!tileset_set[addr])
            send_beat(KIND_TILESET, addr, 16'($urandom), 15'($urandom), 8'($urandom),
                      1'b0, '0);
      end
      send_beat(KIND_RENDER, 16'($urandom), 16'($urandom), prow, tcol, fixed, fixed_pixels);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic is_write, input logic [2:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= is_write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_config(input logic [15:0] pitch, input logic [8:0] width);
      logic [31:0] rdata;
      settle();
      csr_access(1'b1, PITCH_ADDR, {16'($urandom), pitch}, rdata);
      pitch_now = pitch;
      csr_access(1'b0, PITCH_ADDR, '0, rdata);
      if (rdata[15:0] !== pitch)
         flag_failure("pitch readback", 64'(pitch), 64'(rdata[15:0]));
      csr_access(1'b1, WIDTH_ADDR, {23'($urandom), width}, rdata);
      width_now = width;
      csr_access(1'b0, WIDTH_ADDR, '0, rdata);
      if (rdata[8:0] !== width)
         flag_failure("width readback", 64'(width), 64'(rdata[8:0]));
   endtask

   task automatic add_row(input logic [1:0] kind, input logic [15:0] address,
                          input logic [15:0] data, input logic [14:0] prow,
                          input logic [7:0] tcol, input logic fixed,
                          input logic [63:0] pixels);
      stim_row_type r;
      r.kind    = kind;
      r.address = address;
      r.data    = data;
      r.prow    = prow;
      r.tcol    = tcol;
      r.fixed   = fixed;
      r.pixels  = pixels;
      directed_rows.push_back(r);
   endtask

   task automatic random_beat();
      int unsigned sel;
      logic [14:0] prow;
      logic [7:0]  tcol;
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
         if ($urandom_range(0, 9) < 6) begin
            prow = 15'($urandom_range(0, 63));
            tcol = 8'($urandom_range(0, 15));
         end else begin
            prow = 15'($urandom);
            tcol = 8'($urandom);
         end
         render_checked(prow, tcol, 1'b0, '0);
      end else if (sel < 82) begin
         send_beat(KIND_TILESET, 16'($urandom), 16'($urandom), 15'($urandom),
                   8'($urandom), 1'b0, '0);
      end else if (sel < 92) begin
         send_beat(KIND_MAP, 16'($urandom), 16'($urandom), 15'($urandom),
                   8'($urandom), 1'b0, '0);
      end else begin
         send_beat(KIND_UNUSED, 16'($urandom), 16'($urandom), 15'($urandom),
                   8'($urandom), 1'b0, '0);
      end
   endtask

   initial begin
      stim_row_type r;
      int unsigned  phase_end;

      // one tile row of bytes 01..08, upper data byte ignored
      add_row(KIND_TILESET, 16'h0000, 16'hA501, 15'h0, 8'h0, 1'b0, '0);
      add_row(KIND_TILESET, 16'h0001, 16'h5A02, 15'h0, 8'h0, 1'b0, '0);
      add_row(KIND_TILESET, 16'h0002, 16'hFF03, 15'h0, 8'h0, 1'b0, '0);
      add_row(KIND_TILESET, 16'h0003, 16'h0004, 15'h0, 8'h0, 1'b0, '0);
      add_row(KIND_TILESET, 16'h0004, 16'h1205, 15'h0, 8'h0, 1'b0, '0);
      add_row(KIND_TILESET, 16'h0005, 16'h8006, 15'h0, 8'h0, 1'b0, '0);
      add_row(KIND_TILESET, 16'h0006, 16'h4007, 15'h0, 8'h0, 1'b0, '0);
      add_row(KIND_TILESET, 16'h0007, 16'hC308, 15'h0, 8'h0, 1'b0, '0);
      // tile 0 in all four orientations; last index wraps
      add_row(KIND_MAP, 16'h0000, 16'h0000, 15'h0, 8'h0, 1'b0, '0);
      add_row(KIND_MAP, 16'h0001, 16'h8000, 15'h0, 8'h0, 1'b0, '0);
      add_row(KIND_MAP, 16'h0002, 16'h4000, 15'h0, 8'h0, 1'b0, '0);
      add_row(KIND_MAP, 16'h1003, 16'hC000, 15'h0, 8'h0, 1'b0, '0);
      add_row(KIND_RENDER, 16'h0, 16'h0, 15'd0, 8'd0, 1'b1, 64'h0807060504030201);
      add_row(KIND_RENDER, 16'hFFFF, 16'hFFFF, 15'd0, 8'd1, 1'b1, 64'h0102030405060708);
      add_row(KIND_RENDER, 16'h0, 16'h0, 15'd7, 8'd2, 1'b1, 64'h0807060504030201);
      add_row(KIND_RENDER, 16'h0, 16'h0, 15'd7, 8'd3, 1'b1, 64'h0102030405060708);
      // unused kind must not write anything
      add_row(KIND_UNUSED, 16'h0000, 16'hFFFF, 15'h0, 8'h0, 1'b0, '0);
      add_row(KIND_RENDER, 16'h0, 16'h0, 15'd0, 8'd0, 1'b1, 64'h0807060504030201);
      add_row(KIND_TILESET, 16'hFFFF, 16'h005A, 15'h7FFF, 8'hFF, 1'b0, '0);
      add_row(KIND_MAP, 16'hFFFF, 16'hFFFF, 15'h7FFF, 8'hFF, 1'b0, '0);
      add_row(KIND_RENDER, 16'h0, 16'h0, 15'h7FFF, 8'hFF, 1'b0, '0);
      add_row(KIND_RENDER, 16'h0, 16'h0, 15'd1023, 8'd31, 1'b0, '0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         if (r.kind == KIND_RENDER)
            render_checked(r.prow, r.tcol, r.fixed, r.pixels);
         else
            send_beat(r.kind, r.address, r.data, r.prow, r.tcol, 1'b0, '0);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         set_config(phase_pitch[p], phase_width[p]);
         phase_end = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_end)
            random_beat();
      end

      settle();
      if (failures == 0 && pixels_due.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
